// ----- hdl/fud_pkg.sv -----
// Shared types, character constants and the hex digit helper for the form decoder.
package fud_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;
	localparam logic [7:0] OFS_UPPER  = 8'h37;
	localparam logic [7:0] OFS_LOWER  = 8'h57;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// Up to three decoded bytes produced by one item, oldest in slot 0.
	typedef struct packed {
		logic [1:0]      cnt;
		logic            eos;
		logic [2:0][7:0] bytes;
	} burst_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t       r;
		logic [7:0] d;
		begin
			r.ok = 1'b1;
			d    = 8'h00;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - OFS_UPPER;
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - OFS_LOWER;
			end else begin
				r.ok = 1'b0;
			end
			r.nib = d[3:0];
			return r;
		end
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// ----- hdl/fud_decode.sv -----
// Escape state machine: turns one encoded byte into a burst of decoded bytes.
module fud_decode
	import fud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output burst_t     burst
);

	phase_t     phase_q, phase_d;
	logic [3:0] high_nibble_q;
	logic [7:0] first_digit_q;
	hex_t       hx;

	assign hx = hex_value(in_byte);

	always_comb begin
		phase_d = PH_IDLE;
		case (phase_q)
			PH_PCT: begin
				if (!end_of_string && hx.ok) phase_d = PH_DIGIT;
			end
			PH_DIGIT: begin
				phase_d = PH_IDLE;
			end
			default: begin
				if (in_byte == CH_PERCENT && !end_of_string) phase_d = PH_PCT;
			end
		endcase
	end

	always_comb begin
		burst.cnt   = 2'd0;
		burst.eos   = end_of_string;
		burst.bytes = '0;
		case (phase_q)
			PH_PCT: begin
				if (end_of_string) begin
					burst.cnt   = 2'd2;
					burst.bytes = {8'h00, plain_byte(in_byte), CH_PERCENT};
				end else if (!hx.ok) begin
					burst.cnt   = 2'd2;
					burst.bytes = {8'h00, in_byte, CH_PERCENT};
				end
			end
			PH_DIGIT: begin
				if (hx.ok) begin
					burst.cnt   = 2'd1;
					burst.bytes = {16'h0000, high_nibble_q, hx.nib};
				end else begin
					burst.cnt   = 2'd3;
					burst.bytes = {in_byte, first_digit_q, CH_PERCENT};
				end
			end
			default: begin
				if (in_byte == CH_PERCENT) begin
					if (end_of_string) begin
						burst.cnt   = 2'd1;
						burst.bytes = {16'h0000, CH_PERCENT};
					end
				end else begin
					burst.cnt   = 2'd1;
					burst.bytes = {16'h0000, plain_byte(in_byte)};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			high_nibble_q <= 4'h0;
			first_digit_q <= 8'h00;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_PCT && phase_d == PH_DIGIT) begin
				high_nibble_q <= hx.nib;
				first_digit_q <= in_byte;
			end
		end
	end

	// The last byte of a string always leaves the escape machine idle.
	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && end_of_string) |=> (phase_q == PH_IDLE))
		else $error("escape state survived end of string");

	// Only a held first digit can yield a three-byte burst.
	a_three_from_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(burst.cnt == 2'd3) |-> (phase_q == PH_DIGIT))
		else $error("three-byte burst outside digit phase");

	// A silent item is a percent or a valid first digit, never a string end.
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step && burst.cnt == 2'd0) |-> !end_of_string)
		else $error("string ended without a result");

endmodule

// ----- hdl/form_url_decoder_top.sv -----
// Top level of the streaming form-urlencoded decoder.
//
// Input channel: in_valid/in_ready carry one encoded byte per item (in_byte)
// with end_of_string set on the final byte of a string. Output channel:
// out_valid/out_ready carry one decoded byte per item (out_byte); run_last
// marks the last result caused by an input byte and string_done the last
// result of a string. A '+' decodes to a space and '%' plus two hex digits to
// one byte; broken escapes are passed through raw.
// An accepted item waits in the input register, then moves to the burst
// buffer that offers its results. One input item per cycle is taken while
// each byte yields at most one result and the receiver is ready. An item
// that yields several results holds the single input register until its
// last result is taken; the buffer drains one byte per cycle while the
// receiver is ready. Items that yield nothing (a '%' or a held first digit)
// still occupy the input register. Reset clears the escape state and empties
// both registers. When the receiver stalls, the burst buffer holds its byte
// and the input register keeps at most one further item; in_ready then drops.
module form_url_decoder_top
	import fud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eos_s1;
	logic            load;
	logic            pop;
	burst_t          burst;
	logic [1:0]      cnt_q;
	logic            eos_q;
	logic [2:0][7:0] buf_q;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign load      = valid_s1 && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready));
	assign in_ready  = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
	end

	fud_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (load),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.burst         (burst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.bytes;
			eos_q <= burst.eos;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign out_byte    = buf_q[0];
	assign run_last    = (cnt_q == 2'd1);
	assign string_done = (cnt_q == 2'd1) && eos_q;

	// A new burst only replaces the buffer once its last byte leaves.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && cnt_q != 2'd0) |-> (cnt_q == 2'd1 && out_ready))
		else $error("burst overwritten before it drained");

	// Each taken result without a new load shortens the burst by one.
	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("burst count did not step down");

	// A held item in the input register with an empty buffer moves on at once.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cnt_q == 2'd0) |-> load)
		else $error("input register stalled with empty buffer");

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the streaming form-urlencoded decoder: directed escapes, random strings, checker.
`timescale 1ns / 1ps

module testbench;
	import fud_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [7:0] value;
		logic       run_last;
		logic       string_done;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h01;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	// Decoder state as the testbench believes it to be.
	phase_t     dec_phase = PH_IDLE;
	logic [3:0] held_nibble = 4'h0;
	logic [7:0] held_digit = 8'h00;

	decoded_t   expected_bytes[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         items_sent = 0;
	bit         idling_on = 1'b1;
	int         stall_left = 0;

	form_url_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.string_done  (string_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still expected",
				cycle_count, expected_bytes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
	endtask

	// Bit 4 set means the byte is not a hex digit.
	function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return {1'b0, c[3:0]};
		if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic logic [7:0] unplussed(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	// Works out the decoded bytes one accepted input item yields.
	task automatic decode_step(input logic [7:0] c, input logic eos);
		logic [7:0] outs[$];
		logic [4:0] hv;
		decoded_t   d;
		hv = hex_digit_value(c);
		case (dec_phase)
			PH_PCT: begin
				if (eos) begin
					outs = {CH_PERCENT, unplussed(c)};
					dec_phase = PH_IDLE;
				end else if (!hv[4]) begin
					held_nibble = hv[3:0];
					held_digit = c;
					dec_phase = PH_DIGIT;
				end else begin
					outs = {CH_PERCENT, c};
					dec_phase = PH_IDLE;
				end
			end
			PH_DIGIT: begin
				if (!hv[4])
					outs = {{held_nibble, hv[3:0]}};
				else
					outs = {CH_PERCENT, held_digit, c};
				dec_phase = PH_IDLE;
			end
			default: begin
				if (c == CH_PERCENT && !eos)
					dec_phase = PH_PCT;
				else if (c == CH_PERCENT)
					outs = {CH_PERCENT};
				else
					outs = {unplussed(c)};
			end
		endcase
		if (eos)
			dec_phase = PH_IDLE;
		foreach (outs[k]) begin
			d.value = outs[k];
			d.run_last = (k == outs.size() - 1);
			d.string_done = (k == outs.size() - 1) && eos;
			expected_bytes.push_back(d);
		end
	endtask

	// Valid is lowered only ahead of a gap, so it never drops and rises in one step.
	task automatic send_item(input logic [7:0] b, input logic eos);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		decode_step(b, eos);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] random_hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(0, 15));
		if (v < 10)
			return CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
	endfunction

	// Strings are mostly well-formed escapes and text, with broken escapes,
	// raw noise and the occasional string whose last byte is dropped.
	task automatic push_random_string(ref logic [7:0] q[$]);
		int tokens;
		tokens = $urandom_range(1, 6);
		repeat (tokens) begin
			case ($urandom_range(0, 11))
				0, 1, 2: q.push_back(8'($urandom_range(1, 255)));
				3: q.push_back(8'($urandom_range(8'h61, 8'h7A)));
				4: q.push_back(CH_PLUS);
				5, 6, 7, 8: q = {q, CH_PERCENT, random_hex_char(), random_hex_char()};
				9: q = {q, CH_PERCENT, 8'($urandom_range(1, 255))};
				10: q = {q, CH_PERCENT, random_hex_char(), 8'($urandom_range(1, 255))};
				default: q = {q, CH_PERCENT, 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255))};
			endcase
		end
		if (q.size() > 1 && $urandom_range(0, 7) == 0)
			void'(q.pop_back());
	endtask

	task automatic test_random_strings(input int n_items);
		logic [7:0] q[$];
		int target;
		target = items_sent + n_items;
		while (items_sent < target) begin
			q.delete();
			push_random_string(q);
			foreach (q[i])
				send_item(q[i], i == q.size() - 1);
		end
	endtask

	task automatic test_plain_bytes();
		send_item(8'h01, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(8'h7F, 1'b1);
	endtask

	task automatic test_valid_escapes();
		send_text("%4a%F0");
		send_text("%0f");
	endtask

	task automatic test_broken_escapes();
		// A bad first digit, then a bad second digit, then a percent as first digit.
		send_text("%z%AG%%x");
	endtask

	task automatic test_string_ends();
		send_text("%");
		send_text("%+");
		send_text("%%");
		send_text("%7");
	endtask

	task automatic test_drain_pause();
		send_text("%zq%4G");
		wait_for_drain();
		send_text("%41+%e9");
		wait_for_drain();
	endtask

	task automatic test_steady_stream(input int n_items);
		idling_on = 1'b0;
		test_random_strings(n_items);
	endtask

	always @(posedge clk) begin
		if (idling_on && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (idling_on && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 6);
			else
				stall_left <= 0;
		end
	end

	// Outputs are sampled at the falling edge; the handshake then completes
	// at the next rising edge with these same values.
	always @(negedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.value)
					report_mismatch($sformatf("out_byte %02h, wanted %02h",
						out_byte, want.value));
				if (run_last !== want.run_last)
					report_mismatch($sformatf("run_last %b, wanted %b",
						run_last, want.run_last));
				if (string_done !== want.string_done)
					report_mismatch($sformatf("string_done %b, wanted %b",
						string_done, want.string_done));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_valid_escapes();
		test_broken_escapes();
		test_string_ends();
		test_random_strings(220);
		test_drain_pause();
		test_steady_stream(190);
		wait_for_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
